// ===== design/sws_pkg.sv =====
// ---------------------------------------------------------------------------
// sws_pkg
// Shared widths, constants, tables and types of the winner search and update
// block.
// ---------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned CompW  = 16;
  localparam int unsigned DistW  = 33;
  localparam int unsigned MulW   = 17;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned KW     = 5;
  localparam int unsigned NumW   = 11;
  localparam int unsigned DenW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] CFG_RADIUS        = 2'd1;
  localparam logic [1:0] CFG_FLOOR         = 2'd2;
  localparam logic [1:0] CFG_SEED          = 2'd3;

  localparam logic [15:0] LR_RESET    = 16'd6554;
  localparam logic [2:0]  RADIUS_RESET = 3'd1;
  localparam logic [15:0] FLOOR_RESET = 16'd9830;
  localparam logic [15:0] SEED_RESET  = 16'd44257;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic [DistW-1:0] DIST_MAX = {DistW{1'b1}};
  localparam logic [KW-1:0] K_MAX = 5'd16;

  typedef struct packed {
    logic          done;
    logic [KW-1:0] k;
  } kdiv_res_t;

  // One step of the Galois LFSR.
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    lfsr_step = {1'b0, s[15:1]} ^ (s[0] ? LFSR_TAPS : 16'h0000);
  endfunction

  // Gaussian neighbourhood weight in Q1.16, 65536 = 1.0.
  function automatic logic [16:0] gauss(input logic [KW-1:0] k);
    unique case (k)
      5'd0:    gauss = 17'd65536;
      5'd1:    gauss = 17'd61565;
      5'd2:    gauss = 17'd57835;
      5'd3:    gauss = 17'd54331;
      5'd4:    gauss = 17'd51039;
      5'd5:    gauss = 17'd47947;
      5'd6:    gauss = 17'd45042;
      5'd7:    gauss = 17'd42313;
      5'd8:    gauss = 17'd39750;
      5'd9:    gauss = 17'd37341;
      5'd10:   gauss = 17'd35079;
      5'd11:   gauss = 17'd32954;
      5'd12:   gauss = 17'd30957;
      5'd13:   gauss = 17'd29081;
      5'd14:   gauss = 17'd27319;
      5'd15:   gauss = 17'd25664;
      default: gauss = 17'd24109;
    endcase
  endfunction

endpackage

// ===== design/sws_wram.sv =====
// ---------------------------------------------------------------------------
// sws_wram
// Single-port weight memory with a registered read.
// ---------------------------------------------------------------------------
module sws_wram
  import sws_pkg::*;
#(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [CompW-1:0] wdata_i,
  output logic [CompW-1:0] rdata_o
);

  logic [CompW-1:0] mem [Depth];
  logic [CompW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sws_mul.sv =====
// ---------------------------------------------------------------------------
// sws_mul
// Shared registered unsigned multiplier for squares, coefficients and steps.
// ---------------------------------------------------------------------------
module sws_mul
  import sws_pkg::*;
(
  input  logic             clk_i,
  input  logic [MulW-1:0]  a_i,
  input  logic [MulW-1:0]  b_i,
  output logic [ProdW-1:0] p_o
);

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== design/sws_kdiv.sv =====
// ---------------------------------------------------------------------------
// sws_kdiv
// Repeated-subtraction divider for the neighbourhood table index, clamped.
// ---------------------------------------------------------------------------
module sws_kdiv
  import sws_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output kdiv_res_t       res_o
);

  logic            busy_q, done_q;
  logic [NumW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [KW-1:0]   k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if ((rem_q < NumW'(den_q)) || (k_q == K_MAX)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      k_q   <= '0;
    end else if (busy_q && (rem_q >= NumW'(den_q)) && (k_q != K_MAX)) begin
      rem_q <= rem_q - NumW'(den_q);
      k_q   <= k_q + KW'(1);
    end
  end

  assign res_o.done = done_q;
  assign res_o.k    = k_q;

endmodule

// ===== design/som_winner_search_and_update_top.sv =====
// ---------------------------------------------------------------------------
// som_winner_search_and_update_top
// One training step of a self-organizing map: winner search and update.
// ---------------------------------------------------------------------------
// A pattern arrives on the slave stream one component per transaction, tlast
// closing it. Components beyond PATTERN_DIM are dropped; missing ones are zero.
// On tlast the block scans every weight (read, square, accumulate, with one
// shared multiplier), then walks the window around the winner: per neuron it
// starts the table index divider, waits for it and forms the coefficient, and
// skips the neuron if the table weight is not above the floor; else it reads,
// multiplies and writes back each weight. One result transaction (row, column,
// distance) leaves per pattern from an output register; components are accepted
// while it waits, but a pattern that finishes waits until the register is free.
// After reset, and after every seed write, a fill pass writes the LFSR weights
// to every address; no input is accepted meanwhile. Configuration writes are
// taken in any cycle.
// ---------------------------------------------------------------------------
module som_winner_search_and_update_top
  import sws_pkg::*;
#(
  parameter int unsigned MAP_ROWS    = 8,
  parameter int unsigned MAP_COLS    = 8,
  parameter int unsigned PATTERN_DIM = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] component
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] winner_row, [5:3] winner_col, [38:6] best_distance_sq, [39] zero
  output logic [39:0]         m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned WN   = MAP_ROWS * MAP_COLS * PATTERN_DIM;
  localparam int unsigned AW   = (WN > 1) ? $clog2(WN) : 1;
  localparam int unsigned RW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int unsigned CLW  = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int unsigned DIW  = (PATTERN_DIM > 1) ? $clog2(PATTERN_DIM) : 1;
  localparam int unsigned CNTW = $clog2(PATTERN_DIM + 1);
  localparam int unsigned EMX  = (RW > CLW) ? RW : CLW;
  localparam int unsigned EW   = ((EMX > 3) ? EMX : 3) + 1;

  typedef enum logic [12:0] {
    S_FILL = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_SRD  = 13'b0000000000100,
    S_SSQ  = 13'b0000000001000,
    S_SACC = 13'b0000000010000,
    S_WIN  = 13'b0000000100000,
    S_KST  = 13'b0000001000000,
    S_KWT  = 13'b0000010000000,
    S_COEF = 13'b0000100000000,
    S_URD  = 13'b0001000000000,
    S_UMUL = 13'b0010000000000,
    S_UWR  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_e;

  state_e state_q;

  logic [15:0] lr_q, floor_q, lfsr_q;
  logic [2:0]  rad_q;

  logic [CompW-1:0] pbuf_q [PATTERN_DIM];
  logic [CNTW-1:0]  cnt_q;

  logic [AW-1:0]     addr_q;
  logic [DIW-1:0]    d_q;
  logic [RW-1:0]     row_q, best_row_q, r0_q, r1_q;
  logic [CLW-1:0]    col_q, best_col_q, c0_q, c1_q;
  logic [DistW-1:0]  acc_q;
  logic [DistW:0]    best_q;
  logic [MulW-1:0]   coef_q;
  logic [CompW-1:0]  w_q;
  logic              neg_q;
  logic              m_valid_q;
  logic [39:0]       m_data_q;

  // Memory and arithmetic units.
  logic             we;
  logic [CompW-1:0] wdata, rdata;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;
  logic             kstart;
  logic [NumW-1:0]  knum;
  logic [DenW-1:0]  kden;
  kdiv_res_t        kres;

  sws_wram #(.Depth(WN), .AddrW(AW)) u_wram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr_q),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  sws_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  sws_kdiv u_kdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(kstart),
    .num_i  (knum),
    .den_i  (kden),
    .res_o  (kres)
  );

  // Datapath combinational terms.
  logic [15:0]        lfsr_nx;
  logic signed [16:0] diff;
  logic [MulW-1:0]    mag;
  logic [DistW+1:0]   sum;
  logic [DistW-1:0]   acc_nx;
  logic [EW-1:0]      br_e, bc_e, rad_e;
  logic [2:0]         dr, dc;
  logic [6:0]         d2;
  logic [5:0]         rr;
  logic [16:0]        h;
  logic [17:0]        rnd;
  logic signed [18:0] nw;
  logic [CompW-1:0]   nw_sat;
  logic [AW-1:0]      base_addr;
  logic               last_neuron;

  assign lfsr_nx = lfsr_step(lfsr_q);
  assign diff    = $signed({pbuf_q[d_q][15], pbuf_q[d_q]}) - $signed({rdata[15], rdata});
  assign mag     = diff[16] ? MulW'(-diff) : MulW'(diff);
  assign sum     = (DistW + 2)'(acc_q) + (DistW + 2)'(prod);
  assign acc_nx  = (sum > (DistW + 2)'(DIST_MAX)) ? DIST_MAX : DistW'(sum);

  assign br_e  = EW'(best_row_q);
  assign bc_e  = EW'(best_col_q);
  assign rad_e = EW'(rad_q);
  assign dr    = 3'((row_q > best_row_q) ? row_q - best_row_q : best_row_q - row_q);
  assign dc    = 3'((col_q > best_col_q) ? col_q - best_col_q : best_col_q - col_q);
  assign d2    = 7'(dr) * 7'(dr) + 7'(dc) * 7'(dc);
  assign rr    = 6'(rad_q) * 6'(rad_q);
  assign knum  = {d2, 4'b0000} + NumW'(rr);
  assign kden  = (rr == '0) ? DenW'(1) : {rr, 1'b0};
  assign kstart = (state_q == S_KST);
  assign h     = gauss(kres.k);

  // Rounded upper half of the product, shared by coefficient and step size.
  assign rnd   = 18'((prod + ProdW'(32768)) >> 16);
  assign nw    = neg_q ? ($signed({{3{w_q[15]}}, w_q}) - $signed({2'b00, rnd[16:0]}))
                       : ($signed({{3{w_q[15]}}, w_q}) + $signed({2'b00, rnd[16:0]}));
  assign nw_sat = (nw > 19'sd32767)  ? 16'h7FFF :
                  (nw < -19'sd32768) ? 16'h8000 : nw[15:0];

  assign base_addr = AW'((32'(row_q) * MAP_COLS + 32'(col_q)) * PATTERN_DIM);
  assign last_neuron = (col_q == c1_q) && (row_q == r1_q);

  always_comb begin
    mul_a = mag;
    mul_b = mag;
    we    = 1'b0;
    wdata = nw_sat;
    unique case (state_q)
      S_FILL: begin
        we    = 1'b1;
        wdata = {3'b000, lfsr_nx[12:0]} - 16'd4096;
      end
      S_KWT: begin
        mul_a = MulW'(lr_q);
        mul_b = h;
      end
      S_UMUL: begin
        mul_b = coef_q;
      end
      S_UWR: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_FILL;
      lr_q       <= LR_RESET;
      rad_q      <= RADIUS_RESET;
      floor_q    <= FLOOR_RESET;
      lfsr_q     <= SEED_RESET;
      addr_q     <= '0;
      cnt_q      <= '0;
      for (int i = 0; i < PATTERN_DIM; i++) pbuf_q[i] <= '0;
      d_q        <= '0;
      row_q      <= '0;
      col_q      <= '0;
      best_row_q <= '0;
      best_col_q <= '0;
      best_q     <= '1;
      m_valid_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_FILL: begin
          lfsr_q <= lfsr_nx;
          addr_q <= addr_q + AW'(1);
          if (addr_q == AW'(WN - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (cnt_q < CNTW'(PATTERN_DIM)) begin
              pbuf_q[DIW'(cnt_q)] <= s_axis_tdata;
              cnt_q <= cnt_q + CNTW'(1);
            end
            if (s_axis_tlast) begin
              best_q     <= '1;
              best_row_q <= '0;
              best_col_q <= '0;
              addr_q     <= '0;
              d_q        <= '0;
              row_q      <= '0;
              col_q      <= '0;
              acc_q      <= '0;
              state_q    <= S_SRD;
            end
          end
        end
        S_SRD: state_q <= S_SSQ;
        S_SSQ: state_q <= S_SACC;
        S_SACC: begin
          addr_q  <= addr_q + AW'(1);
          state_q <= S_SRD;
          if (d_q == DIW'(PATTERN_DIM - 1)) begin
            d_q   <= '0;
            acc_q <= '0;
            // Less or equal, so the later neuron wins a tie.
            if ({1'b0, acc_nx} <= best_q) begin
              best_q     <= {1'b0, acc_nx};
              best_row_q <= row_q;
              best_col_q <= col_q;
            end
            if (col_q == CLW'(MAP_COLS - 1)) begin
              col_q <= '0;
              row_q <= row_q + RW'(1);
              if (row_q == RW'(MAP_ROWS - 1)) begin
                state_q <= S_WIN;
              end
            end else begin
              col_q <= col_q + CLW'(1);
            end
          end else begin
            d_q   <= d_q + DIW'(1);
            acc_q <= acc_nx;
          end
        end
        S_WIN: begin
          r0_q  <= (br_e > rad_e) ? RW'(br_e - rad_e) : '0;
          r1_q  <= ((br_e + rad_e) < EW'(MAP_ROWS)) ? RW'(br_e + rad_e) : RW'(MAP_ROWS - 1);
          c0_q  <= (bc_e > rad_e) ? CLW'(bc_e - rad_e) : '0;
          c1_q  <= ((bc_e + rad_e) < EW'(MAP_COLS)) ? CLW'(bc_e + rad_e)
                                                      : CLW'(MAP_COLS - 1);
          row_q <= (br_e > rad_e) ? RW'(br_e - rad_e) : '0;
          col_q <= (bc_e > rad_e) ? CLW'(bc_e - rad_e) : '0;
          state_q <= S_KST;
        end
        S_KST: state_q <= S_KWT;
        S_KWT: begin
          if (kres.done) begin
            addr_q <= base_addr;
            d_q    <= '0;
            if (h <= 17'(floor_q)) begin
              if (last_neuron) begin
                state_q <= S_DONE;
              end else begin
                state_q <= S_KST;
                if (col_q == c1_q) begin
                  col_q <= c0_q;
                  row_q <= row_q + RW'(1);
                end else begin
                  col_q <= col_q + CLW'(1);
                end
              end
            end else begin
              state_q <= S_COEF;
            end
          end
        end
        S_COEF: state_q <= S_URD;
        S_URD:  state_q <= S_UMUL;
        S_UMUL: state_q <= S_UWR;
        S_UWR: begin
          if (d_q == DIW'(PATTERN_DIM - 1)) begin
            if (last_neuron) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_KST;
              if (col_q == c1_q) begin
                col_q <= c0_q;
                row_q <= row_q + RW'(1);
              end else begin
                col_q <= col_q + CLW'(1);
              end
            end
          end else begin
            d_q     <= d_q + DIW'(1);
            addr_q  <= addr_q + AW'(1);
            state_q <= S_URD;
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            cnt_q     <= '0;
            for (int i = 0; i < PATTERN_DIM; i++) pbuf_q[i] <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // A seed write restarts the fill pass and drops the pattern in progress.
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LEARNING_RATE: lr_q    <= cfg_data_i;
          CFG_RADIUS:        rad_q   <= cfg_data_i[2:0];
          CFG_FLOOR:         floor_q <= cfg_data_i;
          CFG_SEED: begin
            lfsr_q  <= (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
            addr_q  <= '0;
            cnt_q   <= '0;
            for (int i = 0; i < PATTERN_DIM; i++) pbuf_q[i] <= '0;
            state_q <= S_FILL;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_COEF) begin
      coef_q <= rnd[16:0];
    end
    if (state_q == S_UMUL) begin
      w_q   <= rdata;
      neg_q <= diff[16];
    end
    if ((state_q == S_DONE) && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {1'b0, best_q[DistW-1:0], 3'(best_col_q), 3'(best_row_q)};
    end
  end

  // Assertions.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == S_FILL) || (state_q == S_UWR)))
    else $error("weight write outside fill or update");

  a_best_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WIN) || (state_q == S_DONE)) |-> !best_q[DistW])
    else $error("winner distance not set after scan");

  a_kdiv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kres.done |-> (state_q == S_KWT))
    else $error("divider finished outside its wait state");

  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KST) |-> ((row_q <= r1_q) && (col_q <= c1_q) &&
                            (row_q >= r0_q) && (col_q >= c0_q)))
    else $error("update neuron outside window");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && m_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("result dropped while output stalled");

endmodule
